>>> sv/extended_gcd_bezout_assert.svh
// Assertion macros for the extended GCD block checkers.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef EXTENDED_GCD_BEZOUT_ASSERT_SVH
`define EXTENDED_GCD_BEZOUT_ASSERT_SVH

// Same-cycle implication, gated by reset.
`define EGB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("extended_gcd_bezout: check failed");

// Next-cycle implication, gated by reset.
`define EGB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("extended_gcd_bezout: check failed");

`endif

>>> sv/egcd_pkg.sv
// Shared types and constants for the extended GCD block.
// No dependencies.
`timescale 1ns / 1ps

package egcd_pkg;

  localparam int WIDTH_DEFAULT = 31;
  localparam int COEF_W        = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

>>> sv/egcd_divmac.sv
// Bit-serial restoring divider that also accumulates quotient * coefficient.
// One quotient bit per cycle; depends on egcd_pkg.
`timescale 1ns / 1ps

module egcd_divmac #(
  parameter int WIDTH = egcd_pkg::WIDTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [WIDTH-1:0]           dividend_i,
  input  logic [WIDTH-1:0]           divisor_i,
  input  logic [egcd_pkg::COEF_W-1:0] coef_a_i,
  input  logic [egcd_pkg::COEF_W-1:0] coef_b_i,
  output logic                       done_o,
  output logic [WIDTH-1:0]           rem_o,
  output logic [egcd_pkg::COEF_W-1:0] prod_a_o,
  output logic [egcd_pkg::COEF_W-1:0] prod_b_o
);

  localparam int CntW = $clog2(WIDTH);
  localparam int CW   = egcd_pkg::COEF_W;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [WIDTH-1:0] rem_q, dvd_q;
  logic [CW-1:0]    acc_a_q, acc_b_q;

  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   diff;
  logic             qbit;

  assign rem_sh = {rem_q, dvd_q[WIDTH-1]};
  assign diff   = rem_sh - {1'b0, divisor_i};
  assign qbit   = ~diff[WIDTH];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(WIDTH - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= '0;
      dvd_q   <= dividend_i;
      acc_a_q <= '0;
      acc_b_q <= '0;
    end else if (busy_q) begin
      rem_q   <= qbit ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      dvd_q   <= {dvd_q[WIDTH-2:0], 1'b0};
      acc_a_q <= {acc_a_q[CW-2:0], 1'b0} + (qbit ? coef_a_i : '0);
      acc_b_q <= {acc_b_q[CW-2:0], 1'b0} + (qbit ? coef_b_i : '0);
    end
  end

  assign done_o   = done_q;
  assign rem_o    = rem_q;
  assign prod_a_o = acc_a_q;
  assign prod_b_o = acc_b_q;

endmodule

>>> sv/extended_gcd_bezout.sv
// Channel  | Dir | tdata fields (low bit up)            | Transfer
// s_axis   | in  | a_value, b_value                      | tvalid & tready
// m_axis   | out | divisor, coef_a, coef_b               | tvalid & tready
// Each Euclid step is one bit-serial division; there are up to about 45 steps at WIDTH 31.
// One item at a time: s_axis_tready is high only in idle, from the cycle after the output
// transfer. A result holds on m_axis until taken. Reset is asynchronous, active low.
// Extended GCD top level; depends on egcd_pkg and egcd_divmac.
`timescale 1ns / 1ps

module extended_gcd_bezout #(
  parameter int WIDTH = egcd_pkg::WIDTH_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // a_value, b_value
  input  logic [((2*WIDTH+7)/8)*8-1:0]         s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // divisor, coef_a, coef_b
  output logic [((WIDTH+2*egcd_pkg::COEF_W+7)/8)*8-1:0] m_axis_tdata
);

  localparam int CW   = egcd_pkg::COEF_W;
  localparam int OutW = ((WIDTH + 2*CW + 7) / 8) * 8;

  egcd_pkg::state_e state_q, state_d;

  logic [WIDTH-1:0] r_prev_q, r_cur_q;
  logic [CW-1:0]    ca_prev_q, ca_cur_q, cb_prev_q, cb_cur_q;

  logic             div_start;
  logic             div_done;
  logic [WIDTH-1:0] div_rem;
  logic [CW-1:0]    prod_a, prod_b;
  logic             in_xfer, out_xfer;

  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign out_xfer = m_axis_tvalid & m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      egcd_pkg::ST_IDLE:  if (s_axis_tvalid) state_d = egcd_pkg::ST_CHECK;
      egcd_pkg::ST_CHECK: state_d = (r_cur_q == '0) ? egcd_pkg::ST_DONE : egcd_pkg::ST_DIV;
      egcd_pkg::ST_DIV:   if (div_done) state_d = egcd_pkg::ST_CHECK;
      egcd_pkg::ST_DONE:  if (out_xfer) state_d = egcd_pkg::ST_IDLE;
      default:            state_d = egcd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    div_start     = 1'b0;
    unique case (state_q)
      egcd_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      egcd_pkg::ST_CHECK: div_start = (r_cur_q != '0);
      egcd_pkg::ST_DIV:   ;
      egcd_pkg::ST_DONE:  m_axis_tvalid = 1'b1;
      default:            ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= egcd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      r_prev_q  <= s_axis_tdata[2*WIDTH-1:WIDTH];
      r_cur_q   <= s_axis_tdata[WIDTH-1:0];
      cb_prev_q <= CW'(1);
      cb_cur_q  <= '0;
      ca_prev_q <= '0;
      ca_cur_q  <= CW'(1);
    end else if (state_q == egcd_pkg::ST_DIV && div_done) begin
      r_prev_q  <= r_cur_q;
      r_cur_q   <= div_rem;
      cb_prev_q <= cb_cur_q;
      cb_cur_q  <= cb_prev_q - prod_b;
      ca_prev_q <= ca_cur_q;
      ca_cur_q  <= ca_prev_q - prod_a;
    end
  end

  egcd_divmac #(
    .WIDTH(WIDTH)
  ) u_divmac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (r_prev_q),
    .divisor_i  (r_cur_q),
    .coef_a_i   (ca_cur_q),
    .coef_b_i   (cb_cur_q),
    .done_o     (div_done),
    .rem_o      (div_rem),
    .prod_a_o   (prod_a),
    .prod_b_o   (prod_b)
  );

  assign m_axis_tdata = OutW'({cb_prev_q, ca_prev_q, r_prev_q});

endmodule

>>> sv/egcd_checker.sv
// Port-level checker for the extended GCD block, bound to the top level.
// Depends on extended_gcd_bezout_assert.svh and egcd_pkg.
`timescale 1ns / 1ps
`include "extended_gcd_bezout_assert.svh"

module egcd_checker #(
  parameter int WIDTH = egcd_pkg::WIDTH_DEFAULT
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [((WIDTH+2*egcd_pkg::COEF_W+7)/8)*8-1:0] m_axis_tdata
);

  localparam int CW = egcd_pkg::COEF_W;

  logic [WIDTH-1:0] gcd_out;
  logic [CW-1:0]    coef_a_out, coef_b_out;
  logic             in_xfer, out_xfer, out_wait, gcd_zero;

  assign gcd_out    = m_axis_tdata[WIDTH-1:0];
  assign coef_a_out = m_axis_tdata[WIDTH+CW-1:WIDTH];
  assign coef_b_out = m_axis_tdata[WIDTH+2*CW-1:WIDTH+CW];
  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign out_xfer   = m_axis_tvalid && m_axis_tready;
  assign out_wait   = m_axis_tvalid && !m_axis_tready;
  assign gcd_zero   = m_axis_tvalid && (gcd_out == '0);

  `EGB_ASSERT_NEXT(a_out_hold, out_wait, m_axis_tvalid && $stable(m_axis_tdata))
  `EGB_ASSERT_NOW(a_one_item, 1'b1, !(s_axis_tready && m_axis_tvalid))
  `EGB_ASSERT_NEXT(a_busy_after_in, in_xfer, !s_axis_tready && !m_axis_tvalid)
  `EGB_ASSERT_NEXT(a_idle_after_out, out_xfer, !m_axis_tvalid && s_axis_tready)
  `EGB_ASSERT_NOW(a_zero_gcd, gcd_zero, coef_a_out == '0 && coef_b_out == CW'(1))

endmodule

bind extended_gcd_bezout egcd_checker #(
  .WIDTH(WIDTH)
) u_egcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> bench/extended_gcd_bezout_tb.sv
// Testbench for extended_gcd_bezout: drives operand pairs on s_axis and checks
// each gcd and Bezout pair on m_axis against a built-in iterative Euclid predictor.
// Depends on egcd_pkg and the extended_gcd_bezout RTL.
`timescale 1ns / 1ps

module extended_gcd_bezout_tb;

  localparam int W   = egcd_pkg::WIDTH_DEFAULT;
  localparam int CW  = egcd_pkg::COEF_W;
  localparam int S_W = ((2 * W + 7) / 8) * 8;
  localparam int M_W = ((W + 2 * CW + 7) / 8) * 8;
  localparam logic [W-1:0] OP_MAX = '1;
  localparam int N_RANDOM = 1930;
  localparam int N_CALM   = 250;

  typedef struct {
    logic [W-1:0]  divisor;
    logic [CW-1:0] coef_a;
    logic [CW-1:0] coef_b;
  } bezout_t;

  logic           clk_i;
  logic           rst_ni;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  logic [S_W-1:0] s_axis_tdata;
  logic           m_axis_tvalid;
  logic           m_axis_tready;
  logic [M_W-1:0] m_axis_tdata;

  bezout_t pending_bezout[$];
  int      n_errors;
  int      n_sent;
  int      n_checked;
  bit      gaps_on;
  int      hold_cycles;

  extended_gcd_bezout #(.WIDTH(W)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic bezout_t bezout_of(logic [W-1:0] a, logic [W-1:0] b);
    logic [63:0] r_prev, r_cur, r_next, quot;
    logic [63:0] cb_prev, cb_cur, cb_next, ca_prev, ca_cur, ca_next;
    bezout_t res;
    r_prev  = 64'(b);
    r_cur   = 64'(a);
    cb_prev = 64'd1;
    cb_cur  = 64'd0;
    ca_prev = 64'd0;
    ca_cur  = 64'd1;
    while (r_cur != 64'd0) begin
      quot    = r_prev / r_cur;
      r_next  = r_prev - quot * r_cur;
      cb_next = cb_prev - quot * cb_cur;
      ca_next = ca_prev - quot * ca_cur;
      r_prev  = r_cur;
      r_cur   = r_next;
      cb_prev = cb_cur;
      cb_cur  = cb_next;
      ca_prev = ca_cur;
      ca_cur  = ca_next;
    end
    res.divisor = r_prev[W-1:0];
    res.coef_a  = ca_prev[CW-1:0];
    res.coef_b  = cb_prev[CW-1:0];
    return res;
  endfunction

  function automatic logic [W-1:0] fib_at(int n);
    logic [63:0] f0, f1, fn;
    f0 = 64'd0;
    f1 = 64'd1;
    for (int i = 0; i < n; i++) begin
      fn = f0 + f1;
      f0 = f1;
      f1 = fn;
    end
    return f0[W-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic send_operands(logic [W-1:0] a, logic [W-1:0] b, bit pad_ones = 1'b0);
    logic [S_W-1:0] word;
    int gap;
    word = '0;
    word[W-1:0] = a;
    word[2*W-1:W] = b;
    if (pad_ones) word[S_W-1:2*W] = '1;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_bezout.push_back(bezout_of(a, b));
    n_sent++;
  endtask

  // receiver: random stall bursts, or one long hold-off on request
  initial begin
    int n;
    m_axis_tready <= 1'b0;
    forever begin
      if (hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        n = hold_cycles;
        hold_cycles = 0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 7);
      end else begin
        m_axis_tready <= 1'b1;
        n = gaps_on ? $urandom_range(1, 12) : 1;
      end
      repeat (n) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    bezout_t want;
    logic [W-1:0]  got_div;
    logic [CW-1:0] got_ca, got_cb;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_div = m_axis_tdata[W-1:0];
      got_ca  = m_axis_tdata[W+CW-1:W];
      got_cb  = m_axis_tdata[W+2*CW-1:W+CW];
      if (pending_bezout.size() == 0) begin
        report_mismatch($sformatf("unexpected result divisor=%0d", got_div));
      end else begin
        want = pending_bezout.pop_front();
        n_checked++;
        if (got_div !== want.divisor)
          report_mismatch($sformatf("divisor got %0d want %0d", got_div, want.divisor));
        if (got_ca !== want.coef_a)
          report_mismatch($sformatf("coef_a got %0d want %0d",
                                    $signed(got_ca), $signed(want.coef_a)));
        if (got_cb !== want.coef_b)
          report_mismatch($sformatf("coef_b got %0d want %0d",
                                    $signed(got_cb), $signed(want.coef_b)));
      end
    end
  end

  task automatic test_zero_operands();
    send_operands('0, '0);
    send_operands('0, W'(1));
    send_operands('0, OP_MAX);
    send_operands('0, W'($urandom()));
    send_operands(W'(1), '0);
    send_operands(OP_MAX, '0);
    send_operands(W'($urandom() | 1), '0);
  endtask

  task automatic test_extremes();
    send_operands(OP_MAX, OP_MAX);
    send_operands(W'(1), W'(1));
    send_operands(OP_MAX, W'(1));
    send_operands(W'(1), OP_MAX);
    send_operands(OP_MAX, OP_MAX - W'(1));
    send_operands(OP_MAX - W'(1), OP_MAX);
    send_operands(fib_at(46), fib_at(45));
    send_operands(fib_at(45), fib_at(46));
    send_operands(W'(1) << (W - 1), W'(3) << (W - 3));
    send_operands(W'(12345), W'(12345) * W'(17000));
    send_operands(W'(12345) * W'(17000), W'(12345));
    send_operands(W'(240), W'(46), 1'b1);
    send_operands(W'($urandom()), W'($urandom()), 1'b1);
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_cycles = 3000;
    repeat (4) send_operands(W'($urandom_range(1, 65535)), W'($urandom_range(1, 65535)));
    gaps_on = 1'b1;
  endtask

  task automatic test_random(int count);
    logic [W-1:0] a, b, t;
    int kind, n;
    for (int i = 0; i < count; i++) begin
      if (i == count - N_CALM) gaps_on = 1'b0;
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3, 4: begin
          a = W'($urandom());
          b = W'($urandom());
        end
        5, 6: begin
          a = W'($urandom()) & ((W'(1) << $urandom_range(1, W - 1)) - W'(1));
          b = W'($urandom()) & ((W'(1) << $urandom_range(1, W - 1)) - W'(1));
        end
        7: begin
          n = $urandom_range(1, 45);
          a = fib_at(n + 1);
          b = fib_at(n);
        end
        8: begin
          a = W'($urandom_range(1, 65535));
          b = a * W'($urandom_range(0, 32767));
        end
        default: begin
          n = $urandom_range(0, 2);
          a = (n == 0) ? '0 : W'($urandom());
          b = (n == 1) ? '0 : ((n == 2) ? a : W'($urandom()));
        end
      endcase
      if ($urandom_range(0, 1) == 1) begin
        t = a;
        a = b;
        b = t;
      end
      send_operands(a, b);
    end
  endtask

  initial begin
    n_errors    = 0;
    n_sent      = 0;
    n_checked   = 0;
    gaps_on     = 1'b1;
    hold_cycles = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_operands();
    test_extremes();
    test_backpressure();
    test_random(N_RANDOM);

    s_axis_tvalid <= 1'b0;
    while (pending_bezout.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Covered %0d operand pairs, %0d results checked: zero and extreme operands,",
             n_sent, n_checked);
    $display("worst-case Fibonacci pairs, multiples, padding bits and a long output stall.");
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Timed out with %0d results outstanding", pending_bezout.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
